[design/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg
// Types, widths and constants shared by the quaternion to Euler angle blocks.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int DW         = 16;          // quaternion component width
    localparam int CW         = 40;          // CORDIC vector width
    localparam int ZW         = 28;          // CORDIC angle width, 1/256 centidegree
    localparam int RW         = 63;          // square root datapath width
    localparam int SQRT_STEPS = 32;          // one result bit per stage
    localparam int THR_W      = 14;

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(4608000);   // 180 deg
    localparam logic signed [14:0]   PITCH_UP  = 15'sd9000;
    localparam logic signed [14:0]   PITCH_DN  = -15'sd9000;

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } pole_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } lane_t;

    typedef struct packed {
        logic [RW-1:0] v;
        logic [RW-1:0] r;
    } root_t;

    typedef struct packed {
        pole_t                pc;
        logic signed [CW-1:0] pitch_y;
        logic signed [CW-1:0] yaw_y;
        logic signed [CW-1:0] yaw_x;
        logic signed [CW-1:0] roll_y;
        logic signed [CW-1:0] roll_x;
    } side_t;

    // atan(2^-n) in 1/256 centidegree
    function automatic logic signed [ZW-1:0] arc_entry(input int n);
        logic signed [ZW-1:0] a;
        case (n)
            0:  a = ZW'(1152000);
            1:  a = ZW'(680065);
            2:  a = ZW'(359328);
            3:  a = ZW'(182400);
            4:  a = ZW'(91554);
            5:  a = ZW'(45822);
            6:  a = ZW'(22916);
            7:  a = ZW'(11459);
            8:  a = ZW'(5730);
            9:  a = ZW'(2865);
            10: a = ZW'(1432);
            11: a = ZW'(716);
            12: a = ZW'(358);
            13: a = ZW'(179);
            14: a = ZW'(90);
            15: a = ZW'(45);
            16: a = ZW'(22);
            17: a = ZW'(11);
            18: a = ZW'(6);
            19: a = ZW'(3);
            20: a = ZW'(1);
            21: a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

    // Fold the left half-plane onto the right and seed the angle.
    function automatic lane_t cordic_pre(input logic signed [CW-1:0] y,
                                         input logic signed [CW-1:0] x);
        lane_t l;
        l.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            l.x = -x;
            l.y = -y;
            l.z = (y >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
            l.x = x;
            l.y = y;
            l.z = '0;
        end
        return l;
    endfunction

    // Round half up to centidegrees.
    function automatic logic signed [ZW-1:0] centi(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] s;
        s = z + ZW'(128);
        return s >>> 8;
    endfunction

endpackage

[design/qte_front.sv]
// ----------------------------------------------------------------------------
// qte_front
// Products, pole test, arcsine argument and square root radicand.
// ----------------------------------------------------------------------------
module qte_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [15:0]         quat_w,
    input  logic signed [15:0]         quat_i,
    input  logic signed [15:0]         quat_j,
    input  logic signed [15:0]         quat_k,
    input  logic [qte_pkg::THR_W-1:0]  thr,
    output logic                       out_valid,
    output qte_pkg::root_t             root,
    output qte_pkg::side_t             side
);
    import qte_pkg::*;

    localparam logic signed [33:0] ONE_Q28 = 34'sd1 <<< (2 * FRAC_BITS);
    localparam logic signed [34:0] S_MAX   = 35'sd1 <<< (2 * FRAC_BITS);

    // stage 1
    logic signed [31:0] ij_reg, kw_reg, jw_reg, ik_reg, jj_reg, kk_reg, iw_reg, jk_reg, ii_reg;
    logic signed [DW-1:0] w1_reg, i1_reg;
    logic v1_reg;
    // stage 2
    logic signed [33:0] t2_reg, yy2_reg, yx2_reg, ry2_reg, rx2_reg;
    logic signed [33:0] t2_next, yy2_next, yx2_next, ry2_next, rx2_next;
    logic signed [DW-1:0] w2_reg, i2_reg;
    logic v2_reg;
    // stage 3
    side_t side3_reg, side3_next;
    logic  v3_reg;
    logic signed [33:0] thr34;
    logic signed [34:0] st, sc;
    logic               north, south;
    // stage 4
    logic signed [63:0] sq4_reg;
    side_t side4_reg;
    logic  v4_reg;
    // stage 5
    root_t root5_reg;
    side_t side5_reg;
    logic  v5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ij_reg <= quat_i * quat_j;
            kw_reg <= quat_k * quat_w;
            jw_reg <= quat_j * quat_w;
            ik_reg <= quat_i * quat_k;
            jj_reg <= quat_j * quat_j;
            kk_reg <= quat_k * quat_k;
            iw_reg <= quat_i * quat_w;
            jk_reg <= quat_j * quat_k;
            ii_reg <= quat_i * quat_i;
            w1_reg <= quat_w;
            i1_reg <= quat_i;
        end
    end

    always_comb begin
        t2_next  = 34'(ij_reg) + 34'(kw_reg);
        yy2_next = (34'(jw_reg) - 34'(ik_reg)) <<< 1;
        yx2_next = ONE_Q28 - ((34'(jj_reg) + 34'(kk_reg)) <<< 1);
        ry2_next = (34'(iw_reg) - 34'(jk_reg)) <<< 1;
        rx2_next = ONE_Q28 - ((34'(ii_reg) + 34'(kk_reg)) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t2_reg  <= t2_next;
            yy2_reg <= yy2_next;
            yx2_reg <= yx2_next;
            ry2_reg <= ry2_next;
            rx2_reg <= rx2_next;
            w2_reg  <= w1_reg;
            i2_reg  <= i1_reg;
        end
    end

    always_comb begin
        thr34 = $signed({6'b0, thr, 14'b0});
        north = t2_reg > thr34;
        south = t2_reg < -thr34;
        st    = 35'(t2_reg) <<< 1;
        if (st > S_MAX)
            sc = S_MAX;
        else if (st < -S_MAX)
            sc = -S_MAX;
        else
            sc = st;
        side3_next.pitch_y = CW'(32'(sc) <<< 2);
        side3_next.roll_y  = CW'(ry2_reg);
        side3_next.roll_x  = CW'(rx2_reg);
        if (north || south) begin
            side3_next.pc    = north ? POLE_NORTH : POLE_SOUTH;
            side3_next.yaw_y = CW'(i2_reg) <<< FRAC_BITS;
            side3_next.yaw_x = CW'(w2_reg) <<< FRAC_BITS;
        end else begin
            side3_next.pc    = POLE_NONE;
            side3_next.yaw_y = CW'(yy2_reg);
            side3_next.yaw_x = CW'(yx2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side3_reg <= side3_next;
            sq4_reg   <= $signed(side3_reg.pitch_y[31:0]) * $signed(side3_reg.pitch_y[31:0]);
            side4_reg <= side3_reg;
            root5_reg.v <= (RW'(1) << 60) - sq4_reg[RW-1:0];
            root5_reg.r <= '0;
            side5_reg <= side4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign root      = root5_reg;
    assign side      = side5_reg;

endmodule

[design/qte_isqrt_cell.sv]
// ----------------------------------------------------------------------------
// qte_isqrt_cell
// One restoring square root step: settles one result bit.
// ----------------------------------------------------------------------------
module qte_isqrt_cell #(
    parameter int BIT_POS = 62
) (
    input  logic           aclk,
    input  logic           en,
    input  qte_pkg::root_t din,
    output qte_pkg::root_t dout
);
    import qte_pkg::*;

    localparam logic [RW-1:0] BIT_V = RW'(1) << BIT_POS;

    logic [RW-1:0] trial;
    root_t         dout_reg, dout_next;

    always_comb begin
        trial = din.r + BIT_V;
        if (din.v >= trial) begin
            dout_next.v = din.v - trial;
            dout_next.r = (din.r >> 1) + BIT_V;
        end else begin
            dout_next.v = din.v;
            dout_next.r = din.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[design/qte_cordic_cell.sv]
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  qte_pkg::lane_t din,
    output qte_pkg::lane_t dout
);
    import qte_pkg::*;

    localparam logic signed [ZW-1:0] ARC = arc_entry(SHIFT);

    logic signed [CW-1:0] dx, dy;
    lane_t                dout_reg, dout_next;

    always_comb begin
        dx = din.y >>> SHIFT;
        dy = din.x >>> SHIFT;
        dout_next.zero = din.zero;
        // drive y toward zero
        if (din.y > 0) begin
            dout_next.x = din.x + dx;
            dout_next.y = din.y - dy;
            dout_next.z = din.z + ARC;
        end else begin
            dout_next.x = din.x - dx;
            dout_next.y = din.y + dy;
            dout_next.z = din.z - ARC;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[design/quaternion_to_euler_degrees.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees
// Unit quaternion in Q2.14 to yaw, pitch and roll in centidegrees.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_        in         tdata: quat_w, quat_i, quat_j, quat_k
//  m_        out        tdata: yaw_angle, pitch_angle, roll_angle; tuser: pole_case
//  cfg_      in         pole_threshold write
//
//  One transaction per cycle in steady state while the output is not held. The
//  pipeline is 5 front stages, 32 square root cells, one CORDIC seed stage,
//  CORDIC_STEPS rotation cells and the output register. The whole pipeline
//  holds while a result waits and m_tready is low; s_tready follows. Reset
//  clears valid bits and sets pole_threshold to 8176.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // quat_w, quat_i, quat_j, quat_k
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // yaw_angle[16:0], pitch_angle[14:0], roll_angle[15:0]
    output logic [1:0]  m_tuser,     // pole_case
    input  logic        cfg_wr_en,
    input  logic [13:0] cfg_wr_data
);
    import qte_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             en;

    root_t root_q  [0:SQRT_STEPS];
    side_t side_q  [0:SQRT_STEPS];
    logic  sv_q    [0:SQRT_STEPS];

    lane_t yaw_l   [0:CORDIC_STEPS];
    lane_t pitch_l [0:CORDIC_STEPS];
    lane_t roll_l  [0:CORDIC_STEPS];
    pole_t pc_q    [0:CORDIC_STEPS];
    logic  cv_q    [0:CORDIC_STEPS];

    logic signed [CW-1:0] c_root;
    logic signed [ZW-1:0] yaw_z, yaw_c, pitch_c, roll_c;
    logic [47:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg;
    logic        m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_W'(8176);
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    qte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .quat_w    ($signed(s_tdata[15:0])),
        .quat_i    ($signed(s_tdata[31:16])),
        .quat_j    ($signed(s_tdata[47:32])),
        .quat_k    ($signed(s_tdata[63:48])),
        .thr       (thr_reg),
        .out_valid (sv_q[0]),
        .root      (root_q[0]),
        .side      (side_q[0])
    );

    for (genvar m = 0; m < SQRT_STEPS; m++) begin : g_sqrt
        qte_isqrt_cell #(.BIT_POS(RW - 1 - 2 * m)) u_cell (
            .aclk (aclk),
            .en   (en),
            .din  (root_q[m]),
            .dout (root_q[m+1])
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                side_q[m+1] <= side_q[m];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_q[m+1] <= 1'b0;
            end else if (en) begin
                sv_q[m+1] <= sv_q[m];
            end
        end
    end

    // seed the three CORDIC lanes
    assign c_root = $signed({1'b0, root_q[SQRT_STEPS].r[CW-2:0]});

    always_ff @(posedge aclk) begin
        if (en) begin
            yaw_l[0]   <= cordic_pre(side_q[SQRT_STEPS].yaw_y, side_q[SQRT_STEPS].yaw_x);
            pitch_l[0] <= cordic_pre(side_q[SQRT_STEPS].pitch_y, c_root);
            roll_l[0]  <= cordic_pre(side_q[SQRT_STEPS].roll_y, side_q[SQRT_STEPS].roll_x);
            pc_q[0]    <= side_q[SQRT_STEPS].pc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_q[0] <= 1'b0;
        end else if (en) begin
            cv_q[0] <= sv_q[SQRT_STEPS];
        end
    end

    for (genvar n = 0; n < CORDIC_STEPS; n++) begin : g_cordic
        qte_cordic_cell #(.SHIFT(n)) u_yaw (
            .aclk (aclk),
            .en   (en),
            .din  (yaw_l[n]),
            .dout (yaw_l[n+1])
        );
        qte_cordic_cell #(.SHIFT(n)) u_pitch (
            .aclk (aclk),
            .en   (en),
            .din  (pitch_l[n]),
            .dout (pitch_l[n+1])
        );
        qte_cordic_cell #(.SHIFT(n)) u_roll (
            .aclk (aclk),
            .en   (en),
            .din  (roll_l[n]),
            .dout (roll_l[n+1])
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                pc_q[n+1] <= pc_q[n];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_q[n+1] <= 1'b0;
            end else if (en) begin
                cv_q[n+1] <= cv_q[n];
            end
        end
    end

    always_comb begin
        yaw_z   = yaw_l[CORDIC_STEPS].zero ? '0 : yaw_l[CORDIC_STEPS].z;
        pitch_c = centi(pitch_l[CORDIC_STEPS].zero ? '0 : pitch_l[CORDIC_STEPS].z);
        roll_c  = centi(roll_l[CORDIC_STEPS].zero ? '0 : roll_l[CORDIC_STEPS].z);
        case (pc_q[CORDIC_STEPS])
            POLE_NORTH: begin
                yaw_c        = centi(yaw_z <<< 1);
                m_tdata_next = {16'd0, PITCH_UP, yaw_c[16:0]};
            end
            POLE_SOUTH: begin
                yaw_c        = centi(-(yaw_z <<< 1));
                m_tdata_next = {16'd0, PITCH_DN, yaw_c[16:0]};
            end
            default: begin
                yaw_c        = centi(yaw_z);
                m_tdata_next = {roll_c[15:0], pitch_c[14:0], yaw_c[16:0]};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= pc_q[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cv_q[CORDIC_STEPS];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
